// File: rtl/drsm_pkg.sv
// Shared widths and codes of the discovery receive state machine.
// No dependencies; used by the channel interfaces and the top level.
package drsm_pkg;

  // Field widths of the channels
  localparam int STATE_W = 3;
  localparam int MODE_W  = 2;
  localparam int TTL_W   = 16;

  // Administrative mode codes
  localparam logic [MODE_W-1:0] MODE_DISABLED = 2'd0;
  localparam logic [MODE_W-1:0] MODE_TX_ONLY  = 2'd1;
  localparam logic [MODE_W-1:0] MODE_RX_ONLY  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_RX_TX    = 2'd3;

  // Mode after reset
  localparam logic [MODE_W-1:0] MODE_RESET = MODE_RX_TX;

endpackage

// File: rtl/drsm_if.sv
// Valid/ready channel interfaces of the discovery receive state machine:
// tick input, result output and configuration write. Depends on drsm_pkg.
interface drsm_in_if;
  logic                        valid;
  logic                        ready;
  logic                        port_enabled;
  logic                        frame_arrived;
  logic                        info_aged_event;
  logic [drsm_pkg::TTL_W-1:0]  frame_ttl;
  logic                        frame_changed;

  modport source (
    output valid, port_enabled, frame_arrived, info_aged_event, frame_ttl, frame_changed,
    input  ready
  );
  modport sink (
    input  valid, port_enabled, frame_arrived, info_aged_event, frame_ttl, frame_changed,
    output ready
  );
endinterface

interface drsm_out_if;
  logic                         valid;
  logic                         ready;
  logic [drsm_pkg::STATE_W-1:0] rx_state;
  logic                         delete_aged_cmd;
  logic                         process_frame_cmd;
  logic                         remote_changed;

  modport source (
    output valid, rx_state, delete_aged_cmd, process_frame_cmd, remote_changed,
    input  ready
  );
  modport sink (
    input  valid, rx_state, delete_aged_cmd, process_frame_cmd, remote_changed,
    output ready
  );
endinterface

interface drsm_cfg_if;
  logic                        valid;
  logic                        ready;
  logic [drsm_pkg::MODE_W-1:0] admin_mode;

  modport source (
    output valid, admin_mode,
    input  ready
  );
  modport sink (
    input  valid, admin_mode,
    output ready
  );
endinterface

// File: rtl/discovery_receive_state_machine.sv
// An accepted tick beat passes through the input register, then the result register.
// Throughput: one tick per cycle while the result is taken; the state loop closes
// in the single stage between the input register and the result register.
// A stalled result holds the result register; one more tick waits in
// the input register before in_bus.ready drops.
// Reset (rst_n, synchronous): wait-port-operational state, all flags
// and the latched TTL cleared, admin mode set to receive and transmit.
module discovery_receive_state_machine (
  input  logic          clk,
  input  logic          rst_n,
  drsm_in_if.sink       in_bus,
  drsm_out_if.source    out_bus,
  drsm_cfg_if.sink      cfg_bus
);

  typedef enum logic [drsm_pkg::STATE_W-1:0] {
    ST_WAIT_OPER  = 3'd0,
    ST_DEL_AGED   = 3'd1,
    ST_INIT       = 3'd2,
    ST_WAIT_FRAME = 3'd3,
    ST_FRAME      = 3'd4,
    ST_DEL_INFO   = 3'd5,
    ST_UPDATE     = 3'd6
  } state_t;

  // Machine state
  state_t                         state_r, state_nxt;
  logic                           frame_pending_r, frame_pending_nxt;
  logic                           info_aged_r, info_aged_nxt;
  logic [drsm_pkg::TTL_W-1:0]     latched_ttl_r, latched_ttl_nxt;
  logic                           changes_seen_r, changes_seen_nxt;
  logic                           changed_flag_r, changed_flag_nxt;
  logic [drsm_pkg::MODE_W-1:0]    admin_mode_r;

  // Input register
  logic                           s1_valid_r;
  logic                           s1_port_enabled_r;
  logic                           s1_frame_arrived_r;
  logic                           s1_info_aged_event_r;
  logic [drsm_pkg::TTL_W-1:0]     s1_frame_ttl_r;
  logic                           s1_frame_changed_r;

  // Result register
  logic                           out_valid_r;
  state_t                         out_state_r;
  logic                           out_del_r;
  logic                           out_proc_r;
  logic                           out_changed_r;

  logic   in_accept;
  logic   s1_adv;
  logic   del_cmd;
  logic   proc_cmd;
  logic   fp_set;
  logic   ia_set;
  state_t s_cur;

  // Handshakes
  assign s1_adv         = s1_valid_r && (!out_valid_r || out_bus.ready);
  assign in_bus.ready   = !s1_valid_r || s1_adv;
  assign in_accept      = in_bus.valid && in_bus.ready;
  assign cfg_bus.ready  = 1'b1;

  assign out_bus.valid             = out_valid_r;
  assign out_bus.rx_state          = out_state_r;
  assign out_bus.delete_aged_cmd   = out_del_r;
  assign out_bus.process_frame_cmd = out_proc_r;
  assign out_bus.remote_changed    = out_changed_r;

  // One tick: set flags, force wait-operational on link down without aged info, transition, run the action
  always_comb begin
    fp_set = frame_pending_r | s1_frame_arrived_r;
    ia_set = info_aged_r | s1_info_aged_event_r;
    s_cur  = (!ia_set && !s1_port_enabled_r) ? ST_WAIT_OPER : state_r;

    case (s_cur)
      ST_WAIT_OPER: begin
        if (ia_set)                 state_nxt = ST_DEL_AGED;
        else if (s1_port_enabled_r) state_nxt = ST_INIT;
        else                        state_nxt = ST_WAIT_OPER;
      end
      ST_DEL_AGED: state_nxt = ST_WAIT_OPER;
      ST_INIT: begin
        if (admin_mode_r == drsm_pkg::MODE_RX_ONLY ||
            admin_mode_r == drsm_pkg::MODE_RX_TX) state_nxt = ST_WAIT_FRAME;
        else                                      state_nxt = ST_INIT;
      end
      ST_WAIT_FRAME: begin
        if (ia_set)      state_nxt = ST_DEL_INFO;
        else if (fp_set) state_nxt = ST_FRAME;
        else             state_nxt = ST_WAIT_FRAME;
      end
      ST_FRAME: begin
        if (latched_ttl_r == '0) state_nxt = ST_DEL_INFO;
        else if (changes_seen_r) state_nxt = ST_UPDATE;
        else                     state_nxt = ST_WAIT_FRAME;
      end
      ST_DEL_INFO: state_nxt = ST_WAIT_FRAME;
      ST_UPDATE:   state_nxt = ST_WAIT_FRAME;
      default:     state_nxt = ST_WAIT_OPER;
    endcase

    frame_pending_nxt = fp_set;
    info_aged_nxt     = ia_set;
    latched_ttl_nxt   = latched_ttl_r;
    changes_seen_nxt  = changes_seen_r;
    changed_flag_nxt  = changed_flag_r;
    del_cmd           = 1'b0;
    proc_cmd          = 1'b0;

    case (state_nxt)
      ST_DEL_AGED: begin
        changed_flag_nxt = 1'b1;
        info_aged_nxt    = 1'b0;
        del_cmd          = 1'b1;
      end
      ST_INIT: begin
        frame_pending_nxt = 1'b0;
        info_aged_nxt     = 1'b0;
        del_cmd           = 1'b1;
      end
      ST_WAIT_FRAME: begin
        info_aged_nxt    = 1'b0;
        changed_flag_nxt = 1'b0;
      end
      ST_FRAME: begin
        frame_pending_nxt = 1'b0;
        latched_ttl_nxt   = s1_frame_ttl_r;
        changes_seen_nxt  = s1_frame_changed_r;
        proc_cmd          = 1'b1;
      end
      ST_DEL_INFO: begin
        changed_flag_nxt = 1'b1;
        del_cmd          = 1'b1;
      end
      ST_UPDATE: begin
        changed_flag_nxt = 1'b1;
      end
      default: begin
      end
    endcase
  end

  // Hold state, input beat and result beat
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r         <= ST_WAIT_OPER;
      frame_pending_r <= 1'b0;
      info_aged_r     <= 1'b0;
      latched_ttl_r   <= '0;
      changes_seen_r  <= 1'b0;
      changed_flag_r  <= 1'b0;
      admin_mode_r    <= drsm_pkg::MODE_RESET;
      s1_valid_r      <= 1'b0;
      out_valid_r     <= 1'b0;
    end else begin
      if (cfg_bus.valid && cfg_bus.ready) begin
        admin_mode_r <= cfg_bus.admin_mode;
      end

      // Capture an accepted tick beat
      if (in_accept) begin
        s1_valid_r           <= 1'b1;
        s1_port_enabled_r    <= in_bus.port_enabled;
        s1_frame_arrived_r   <= in_bus.frame_arrived;
        s1_info_aged_event_r <= in_bus.info_aged_event;
        s1_frame_ttl_r       <= in_bus.frame_ttl;
        s1_frame_changed_r   <= in_bus.frame_changed;
      end else if (s1_adv) begin
        s1_valid_r <= 1'b0;
      end

      // Commit the tick and load its result
      if (s1_adv) begin
        state_r         <= state_nxt;
        frame_pending_r <= frame_pending_nxt;
        info_aged_r     <= info_aged_nxt;
        latched_ttl_r   <= latched_ttl_nxt;
        changes_seen_r  <= changes_seen_nxt;
        changed_flag_r  <= changed_flag_nxt;
        out_valid_r     <= 1'b1;
        out_state_r     <= state_nxt;
        out_del_r       <= del_cmd;
        out_proc_r      <= proc_cmd;
        out_changed_r   <= changed_flag_nxt;
      end else if (out_bus.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

`ifndef NO_ASSERTIONS
  // Process command only ever comes with the frame state
  assert property (@(posedge clk) disable iff (!rst_n)
    out_bus.valid && out_bus.process_frame_cmd |-> out_bus.rx_state == ST_FRAME)
    else $error("process command outside frame state");

  // Input stalls only when both stages are full and the result is held
  assert property (@(posedge clk) disable iff (!rst_n)
    !in_bus.ready |-> s1_valid_r && out_valid_r && !out_bus.ready)
    else $error("input stalled with free room");

  // Entering wait-for-frame clears the change flag
  assert property (@(posedge clk) disable iff (!rst_n)
    s1_adv && state_nxt == ST_WAIT_FRAME |=> !changed_flag_r && !out_changed_r)
    else $error("change flag not cleared in wait-for-frame");

  // While a result is held, the state and the change flag do not move
  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_bus.ready |=> $stable(state_r) && $stable(changed_flag_r))
    else $error("state advanced while result stalled");
`endif

endmodule
